// ----- hdl/b2d_pkg.sv -----
// Shared constants, types and helpers for the binary-to-decimal digit converter.
// Has no dependencies; every other file in hdl/ refers to it by scoped names.
package b2d_pkg;

    localparam int B2D_VALUE_W    = 64;
    localparam int B2D_DIGIT_W    = 4;
    localparam int B2D_COUNT_W    = 5;
    localparam int B2D_VALUE_BITS = 64;

    // Decimal digits needed for 2**bits - 1. This is floor(bits * log10(2)) + 1,
    // which is exact because no power of two is a power of ten.
    function automatic int b2d_num_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_b2d_state;

endpackage

// ----- hdl/b2d_if.sv -----
// Valid/ready channel interfaces for the converter's input and result words.
// Depends on b2d_pkg for the field widths.
interface b2d_in_if;
    logic                           valid;
    logic                           ready;
    logic [b2d_pkg::B2D_VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
    logic                            valid;
    logic                            ready;
    logic [b2d_pkg::B2D_DIGIT_W-1:0] digit;
    logic [b2d_pkg::B2D_COUNT_W-1:0] digit_count;
    logic                            is_last;

    modport source (output valid, output digit, output digit_count, output is_last,
                    input ready);
    modport sink   (input valid, input digit, input digit_count, input is_last,
                    output ready);
endinterface

// ----- hdl/b2d_dabble.sv -----
// Bit-serial double-dabble core: shifts one binary bit per cycle into a BCD register
// and tracks the decimal digit count as it goes. Depends on b2d_pkg.
module b2d_dabble #(
    parameter int VALUE_BITS = b2d_pkg::B2D_VALUE_BITS,
    parameter int NDIG       = b2d_pkg::b2d_num_digits(VALUE_BITS),
    parameter int CW         = $clog2(NDIG + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [VALUE_BITS-1:0]                 i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [NDIG-1:0][b2d_pkg::B2D_DIGIT_W-1:0] o_bcd,
    output logic [CW-1:0]                         o_count
);
    localparam int DIW = $clog2(NDIG);
    localparam int BW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DW  = b2d_pkg::B2D_DIGIT_W;

    b2d_pkg::t_b2d_state r_state, n_state;

    logic [VALUE_BITS-1:0]         r_bin, n_bin;
    logic [NDIG-1:0][DW-1:0]       r_bcd, n_bcd;
    logic [NDIG-1:0][DW-1:0]       w_adj;
    logic [NDIG*DW-1:0]            w_adj_flat;
    logic [NDIG-1:0][DW-1:0]       w_shifted;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [BW-1:0]                 r_bit, n_bit;

    // Add-3 correction on every digit of five or more, then shift in the next bit.
    always_comb begin
        for (int j = 0; j < NDIG; j++) begin
            w_adj[j] = (r_bcd[j] >= DW'(5)) ? r_bcd[j] + DW'(3) : r_bcd[j];
        end
        w_adj_flat = w_adj;
        w_shifted  = {w_adj_flat[NDIG*DW-2:0], r_bin[VALUE_BITS-1]};
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            b2d_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_cnt   = CW'(1);
                    n_bit   = '0;
                    n_state = b2d_pkg::S_SHIFT;
                end
            end
            b2d_pkg::S_SHIFT: begin
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_bcd = w_shifted;
                // The value at most doubles per shift, so the count grows by one at most.
                if (r_cnt < CW'(NDIG) && w_shifted[r_cnt[DIW-1:0]] != '0) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_bit = r_bit + BW'(1);
                if (r_bit == BW'(VALUE_BITS - 1)) begin
                    n_state = b2d_pkg::S_DONE;
                end
            end
            b2d_pkg::S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = b2d_pkg::S_IDLE;
                end
            end
            default: n_state = b2d_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2d_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_bit <= n_bit;
    end

    assign o_bcd   = r_bcd;
    assign o_count = r_cnt;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != b2d_pkg::S_IDLE |-> (r_cnt >= CW'(1) && r_cnt <= CW'(NDIG)))
        else $error("digit count out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2d_pkg::S_IDLE && i_valid) |=> (r_state == b2d_pkg::S_SHIFT
        && r_bit == '0 && r_cnt == CW'(1)))
        else $error("conversion did not start cleanly");

    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2d_pkg::S_DONE && r_cnt > CW'(1))
        |-> r_bcd[DIW'(r_cnt - CW'(1))] != '0)
        else $error("most significant counted digit is zero");

endmodule

// ----- hdl/b2d_emit.sv -----
// Digit emitter: holds one converted BCD word in registers, sends its digits
// out one per cycle if i_ready, least significant first. Depends on b2d_pkg.
module b2d_emit #(
    parameter int VALUE_BITS = b2d_pkg::B2D_VALUE_BITS,
    parameter int NDIG       = b2d_pkg::b2d_num_digits(VALUE_BITS),
    parameter int CW         = $clog2(NDIG + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [NDIG-1:0][b2d_pkg::B2D_DIGIT_W-1:0] i_bcd,
    input  logic [CW-1:0]                             i_count,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [b2d_pkg::B2D_DIGIT_W-1:0]           o_digit,
    output logic [b2d_pkg::B2D_COUNT_W-1:0]           o_digit_count,
    output logic                                      o_is_last
);
    localparam int DW = b2d_pkg::B2D_DIGIT_W;

    logic                    r_busy, n_busy;
    logic [NDIG-1:0][DW-1:0] r_bcd, n_bcd;
    logic [CW-1:0]           r_left, n_left;
    logic [CW-1:0]           r_tot, n_tot;
    logic                    w_last;
    logic                    w_take;

    assign w_last  = (r_left == CW'(1));
    assign o_ready = !r_busy || (i_ready && w_last);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_busy = r_busy;
        n_bcd  = r_bcd;
        n_left = r_left;
        n_tot  = r_tot;
        if (r_busy && i_ready) begin
            n_bcd  = {DW'(0), r_bcd[NDIG-1:1]};
            n_left = r_left - CW'(1);
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
        if (w_take) begin
            n_bcd  = i_bcd;
            n_left = i_count;
            n_tot  = i_count;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_left <= n_left;
        r_tot  <= n_tot;
    end

    assign o_valid       = r_busy;
    assign o_digit       = r_bcd[0];
    assign o_digit_count = b2d_pkg::B2D_COUNT_W'(r_tot);
    assign o_is_last     = w_last;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left >= CW'(1) && r_left <= r_tot))
        else $error("remaining digit count out of range");

    a_msd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last && r_tot > CW'(1)) |-> r_bcd[0] != '0)
        else $error("leading zero emitted as last digit");

    a_digit_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_bcd[0] <= DW'(9))
        else $error("digit is not decimal");

endmodule

// ----- hdl/binary_to_decimal_digits.sv -----
// Binary to decimal digit converter: each input word is an unsigned value whose low
// VALUE_BITS bits are converted by bit-serial double dabble, one bit per cycle. In the
// converter an item passes through load, VALUE_BITS shifts and hand-off; then its digits
// leave one word per cycle while the output is ready, least significant first, each
// carrying the total digit count and a last flag on the most significant digit; zero
// gives the single digit 0. The emitter drains one item while the converter works on
// the next, so the sustained item rate is set by the shift loop. Depends on b2d_pkg,
// b2d_if, b2d_dabble and b2d_emit.
module binary_to_decimal_digits #(
    parameter int VALUE_BITS = b2d_pkg::B2D_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2d_in_if.sink     i_in,
    b2d_out_if.source  o_out
);
    localparam int NDIG = b2d_pkg::b2d_num_digits(VALUE_BITS);
    localparam int CW   = $clog2(NDIG + 1);

    logic                                      w_xfer_valid;
    logic                                      w_xfer_ready;
    logic [NDIG-1:0][b2d_pkg::B2D_DIGIT_W-1:0] w_bcd;
    logic [CW-1:0]                             w_count;

    b2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG),
        .CW         (CW)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_value (i_in.value[VALUE_BITS-1:0]),
        .o_valid (w_xfer_valid),
        .i_ready (w_xfer_ready),
        .o_bcd   (w_bcd),
        .o_count (w_count)
    );

    b2d_emit #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG),
        .CW         (CW)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_xfer_valid),
        .o_ready       (w_xfer_ready),
        .i_bcd         (w_bcd),
        .i_count       (w_count),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_digit       (o_out.digit),
        .o_digit_count (o_out.digit_count),
        .o_is_last     (o_out.is_last)
    );

endmodule
